>>> rtl/rbim_pkg.sv
// Shared types, widths and helpers for the reference block index map.
// No dependencies; imported by every module of the block.
package rbim_pkg;

	// field and datapath widths
	localparam int LANE_W        = 8;
	localparam int COL_W         = 24;
	localparam int QCNT_W        = 25;
	localparam int POS_W         = 26;
	localparam int RAND_W        = 32;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	// lane modulo: quotient bits retired per pipeline stage
	localparam int MOD_STEP_BITS = 4;
	localparam int MOD_STAGES    = RAND_W / MOD_STEP_BITS;

	// slice index reaches 6 for tiny segments (column count 7, segment 1)
	localparam int MAX_SLICE     = 6;
	localparam int SLICE_W       = 3;
	localparam int MULT_N        = MAX_SLICE + 2;

	// stages of range classification before the lane compare
	localparam int CLS_STAGES    = 3;

	// register map, word index taken from paddr[2]
	typedef enum logic [0:0] {
		REG_LANE_COUNT   = 1'b0,
		REG_COLUMN_COUNT = 1'b1
	} reg_idx_t;

	// configuration as seen by the datapath; segm[k] = k * segment
	typedef struct packed {
		logic [LANE_W-1:0]                lanes;
		logic [QCNT_W-1:0]                q;
		logic [MULT_N-1:0][POS_W-1:0]     segm;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic              empty;
		logic [LANE_W-1:0] lane;
		logic [QCNT_W-1:0] card;
		logic [POS_W-1:0]  start;
		logic [QCNT_W-1:0] span_a;
		logic [RAND_W-1:0] x;
	} job_t;

	// queue status toward the back end and the top level
	typedef struct packed {
		logic not_empty;
		logic full;
	} q_status_t;

	// restoring remainder step over a few dividend bits
	function automatic logic [LANE_W-1:0] mod_step(
		input logic [LANE_W-1:0]        rem,
		input logic [MOD_STEP_BITS-1:0] bits,
		input logic [LANE_W-1:0]        d
	);
		logic [LANE_W:0] r;
		r = {1'b0, rem};
		for (int k = MOD_STEP_BITS - 1; k >= 0; k--) begin
			r = {r[LANE_W-1:0], bits[k]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
			end
		end
		return r[LANE_W-1:0];
	endfunction

endpackage

>>> rtl/rbim_front.sv
// Front end: accepts items, computes the lane modulo and classifies the range.
// Depends on rbim_pkg; feeds rbim_queue.
module rbim_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rbim_pkg::cfg_t              cfg,
	input  logic                        accept,
	input  logic [rbim_pkg::LANE_W-1:0] lane_index,
	input  logic [rbim_pkg::COL_W-1:0]  column_index,
	input  logic                        first_pass,
	input  logic [rbim_pkg::RAND_W-1:0] rand_low,
	input  logic [rbim_pkg::RAND_W-1:0] rand_high,
	output logic                        push,
	output rbim_pkg::job_t              push_job
);
	import rbim_pkg::*;

	typedef struct packed {
		logic              empty;
		logic              first;
		logic              slice0;
		logic [LANE_W-1:0] lane_i;
		logic [RAND_W-1:0] x;
		logic [POS_W-1:0]  start;
		logic [QCNT_W-1:0] span_a;
		logic [QCNT_W-1:0] card_first;
		logic [QCNT_W-1:0] card_same;
		logic [QCNT_W-1:0] card_other;
	} cls_t;

	logic [MOD_STAGES:1]    vld_s;
	logic [LANE_W-1:0]      rem_s [1:MOD_STAGES];
	logic [RAND_W-1:0]      dvd_s [1:MOD_STAGES];

	// stage 1: column substitution, slice search, J1 square
	logic [QCNT_W-1:0]      jj_c;
	logic                   empty_c;
	logic [SLICE_W-1:0]     slice_c;
	logic [2*RAND_W-1:0]    sq_c;
	logic [QCNT_W-1:0]      jj_s1;
	logic                   empty_s1;
	logic [SLICE_W-1:0]     slice_s1;
	logic                   first_s1;
	logic [LANE_W-1:0]      lane_i_s1;
	logic [RAND_W-1:0]      x_s1;

	// stage 2: range bounds
	logic [POS_W-1:0]       sseg_c;
	logic [POS_W-1:0]       start_c;
	logic [QCNT_W-1:0]      a_s2;
	logic [POS_W-1:0]       start_s2;
	logic [QCNT_W-1:0]      bj_s2;
	logic [QCNT_W-1:0]      sseg_s2;
	logic                   jmod0_s2;
	logic                   slice0_s2;
	logic                   empty_s2;
	logic                   first_s2;
	logic [LANE_W-1:0]      lane_i_s2;
	logic [RAND_W-1:0]      x_s2;

	// stage 3 onward: candidate counts, delayed to meet the lane result
	logic [QCNT_W:0]        sum_same_c;
	logic [POS_W-1:0]       sum_other_c;
	logic [POS_W-1:0]       sum_dec_c;
	cls_t                   cls_s [CLS_STAGES:MOD_STAGES];

	// final pick once the lane is known
	cls_t                   fin;
	logic [LANE_W-1:0]      lane_mod;
	logic [QCNT_W-1:0]      card_c;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[MOD_STAGES-1:1], accept};
		end
	end

	// lane modulo pipeline, most significant bits first
	always_ff @(posedge clk) begin
		rem_s[1] <= mod_step('0, rand_high[RAND_W-1 -: MOD_STEP_BITS], cfg.lanes);
		dvd_s[1] <= rand_high;
	end

	for (genvar k = 2; k <= MOD_STAGES; k++) begin : g_mod
		always_ff @(posedge clk) begin
			rem_s[k] <= mod_step(rem_s[k-1],
				dvd_s[k-1][RAND_W-1-MOD_STEP_BITS*(k-1) -: MOD_STEP_BITS], cfg.lanes);
			dvd_s[k] <= dvd_s[k-1];
		end
	end

	// stage 1 logic
	assign sq_c = {{RAND_W{1'b0}}, rand_low} * {{RAND_W{1'b0}}, rand_low};

	always_comb begin
		if (column_index == '0 && cfg.q != '0) begin
			jj_c = cfg.q - QCNT_W'(1);
		end else begin
			jj_c = QCNT_W'(column_index);
		end
		empty_c = (cfg.segm[1] == '0) || (jj_c >= cfg.q);
		slice_c = '0;
		for (int k = 1; k <= MAX_SLICE; k++) begin
			if (POS_W'(jj_c) >= cfg.segm[k]) begin
				slice_c = SLICE_W'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		jj_s1     <= jj_c;
		empty_s1  <= empty_c;
		slice_s1  <= slice_c;
		first_s1  <= first_pass;
		lane_i_s1 <= lane_index;
		x_s1      <= sq_c[2*RAND_W-1:RAND_W];
	end

	// stage 2 logic
	assign sseg_c  = cfg.segm[slice_s1];
	assign start_c = cfg.segm[SLICE_W'(slice_s1 + SLICE_W'(1))];

	always_ff @(posedge clk) begin
		a_s2      <= (POS_W'(cfg.q) > start_c) ? QCNT_W'(POS_W'(cfg.q) - start_c) : '0;
		start_s2  <= start_c;
		bj_s2     <= (jj_s1 != '0) ? jj_s1 - QCNT_W'(1) : '0;
		sseg_s2   <= QCNT_W'(sseg_c);
		jmod0_s2  <= (POS_W'(jj_s1) == sseg_c);
		slice0_s2 <= (slice_s1 == '0);
		empty_s2  <= empty_s1;
		first_s2  <= first_s1;
		lane_i_s2 <= lane_i_s1;
		x_s2      <= x_s1;
	end

	// stage 3 logic: counts for every lane outcome
	assign sum_same_c  = {1'b0, a_s2} + {1'b0, bj_s2};
	assign sum_other_c = POS_W'(a_s2) + POS_W'(sseg_s2);
	assign sum_dec_c   = sum_other_c - POS_W'(1);

	always_ff @(posedge clk) begin
		cls_s[CLS_STAGES].empty      <= empty_s2;
		cls_s[CLS_STAGES].first      <= first_s2;
		cls_s[CLS_STAGES].slice0     <= slice0_s2;
		cls_s[CLS_STAGES].lane_i     <= lane_i_s2;
		cls_s[CLS_STAGES].x          <= x_s2;
		cls_s[CLS_STAGES].start      <= start_s2;
		cls_s[CLS_STAGES].span_a     <= a_s2;
		cls_s[CLS_STAGES].card_first <= slice0_s2 ? bj_s2 : sseg_s2;
		cls_s[CLS_STAGES].card_same  <= sum_same_c[QCNT_W-1:0];
		// other lane: the block just before the segment start is dropped
		if (jmod0_s2 && sum_other_c != '0) begin
			cls_s[CLS_STAGES].card_other <= QCNT_W'(sum_dec_c);
		end else begin
			cls_s[CLS_STAGES].card_other <= QCNT_W'(sum_other_c);
		end
	end

	for (genvar k = CLS_STAGES + 1; k <= MOD_STAGES; k++) begin : g_dly
		always_ff @(posedge clk) begin
			cls_s[k] <= cls_s[k-1];
		end
	end

	// final selection on lane outcome
	assign fin      = cls_s[MOD_STAGES];
	assign lane_mod = rem_s[MOD_STAGES];

	always_comb begin
		push_job   = '0;
		push_job.x = fin.x;
		if (fin.first) begin
			card_c          = fin.card_first;
			push_job.lane   = fin.slice0 ? fin.lane_i : lane_mod;
			push_job.start  = '0;
			push_job.span_a = '0;
		end else begin
			card_c          = (lane_mod == fin.lane_i) ? fin.card_same : fin.card_other;
			push_job.lane   = lane_mod;
			push_job.start  = fin.start;
			push_job.span_a = fin.span_a;
		end
		push_job.card  = card_c;
		push_job.empty = fin.empty || (card_c == '0);
	end

	assign push = vld_s[MOD_STAGES];

endmodule

>>> rtl/rbim_queue.sv
// Short item queue between the front and back ends.
// Depends on rbim_pkg for the job and status types.
module rbim_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rbim_pkg::job_t       push_job,
	input  logic                 pop,
	output rbim_pkg::job_t       head_job,
	output rbim_pkg::q_status_t  status
);
	import rbim_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign do_pop  = pop && (count_q != '0);
	assign do_push = push && ((count_q != CNT_W'(DEPTH)) || do_pop);

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign head_job         = mem_q[rd_ptr_q];
	assign status.not_empty = (count_q != '0);
	assign status.full      = (count_q == CNT_W'(DEPTH));

endmodule

>>> rtl/rbim_back.sv
// Back end: scales J1 onto the candidate count and resolves the column.
// Depends on rbim_pkg; drains rbim_queue one item per cycle.
module rbim_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rbim_pkg::q_status_t         status,
	input  rbim_pkg::job_t              head_job,
	output logic                        pop,
	output logic                        done,
	output logic [rbim_pkg::LANE_W-1:0] ref_lane,
	output logic [rbim_pkg::COL_W-1:0]  ref_column,
	output logic                        empty_set
);
	import rbim_pkg::*;

	logic [QCNT_W+RAND_W-1:0] prod_c;
	logic [QCNT_W-1:0]        col_lo_c;

	logic              vld_s1;
	job_t              job_s1;
	logic [QCNT_W-1:0] y_s1;

	logic              vld_s2;
	logic              empty_s2;
	logic [LANE_W-1:0] lane_s2;
	logic [POS_W-1:0]  start_s2;
	logic [QCNT_W-1:0] a_s2;
	logic [QCNT_W-1:0] z_s2;

	logic              done_q;
	logic              empty_q;
	logic [LANE_W-1:0] lane_q;
	logic [COL_W-1:0]  col_q;

	// never holds off: take the head whenever there is one
	assign pop = status.not_empty;

	// y = card * x >> 32
	assign prod_c = {{RAND_W{1'b0}}, head_job.card} * {{QCNT_W{1'b0}}, head_job.x};

	// column inside the wrapped range or after it
	assign col_lo_c = z_s2 - a_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= pop;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		job_s1   <= head_job;
		y_s1     <= prod_c[QCNT_W+RAND_W-1:RAND_W];
		// position counted from the far end of the list
		z_s2     <= job_s1.card - QCNT_W'(1) - y_s1;
		empty_s2 <= job_s1.empty;
		lane_s2  <= job_s1.lane;
		start_s2 <= job_s1.start;
		a_s2     <= job_s1.span_a;
		empty_q  <= empty_s2;
		if (empty_s2) begin
			lane_q <= '0;
			col_q  <= '0;
		end else begin
			lane_q <= lane_s2;
			col_q  <= (z_s2 < a_s2) ? COL_W'(start_s2 + POS_W'(z_s2)) : COL_W'(col_lo_c);
		end
	end

	assign done       = done_q;
	assign ref_lane   = lane_q;
	assign ref_column = col_q;
	assign empty_set  = empty_q;

endmodule

>>> rtl/reference_block_index_map.sv
// Reference block index map: top level with APB register file.
// Depends on rbim_pkg, rbim_front, rbim_queue and rbim_back.
//
// Usage:
//   Configure lane_count (0x0) and column_count (0x4) over the APB port
//   while no item is in flight. Reads return the written values.
//   Raise start with lane_index, column_index, first_pass, rand_low and
//   rand_high; the item is taken at the edge where start is high and
//   busy is low. One item may be taken every cycle.
//   Each item yields one result on ref_lane, ref_column and empty_set,
//   marked by done for exactly one cycle, in order. Each item passes
//   through the lane modulo pipeline (J2 mod lanes, four quotient
//   bits per stage over eight stages), then the queue and three
//   back-end stages (scale multiply, offset, column). The receiver
//   cannot hold results off; the back end drains the queue every
//   cycle, so busy stays low in normal use.
//   Reset clears all in-flight items and loads lane_count 1 and
//   column_count 8.
module reference_block_index_map #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rbim_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rbim_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rbim_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            start,
	output logic                            busy,
	input  logic [rbim_pkg::LANE_W-1:0]     lane_index,
	input  logic [rbim_pkg::COL_W-1:0]      column_index,
	input  logic                            first_pass,
	input  logic [rbim_pkg::RAND_W-1:0]     rand_low,
	input  logic [rbim_pkg::RAND_W-1:0]     rand_high,
	output logic                            done,
	output logic [rbim_pkg::LANE_W-1:0]     ref_lane,
	output logic [rbim_pkg::COL_W-1:0]      ref_column,
	output logic                            empty_set
);
	import rbim_pkg::*;

	logic                         cfg_wr;
	reg_idx_t                     reg_idx;
	logic [LANE_W-1:0]            lane_count_q;
	logic [QCNT_W-1:0]            column_count_q;
	logic [LANE_W-1:0]            lanes_eff_q;
	logic [MULT_N-1:0][POS_W-1:0] segm_q;
	cfg_t                         cfg;

	logic                         accept;
	logic                         push;
	job_t                         push_job;
	job_t                         head_job;
	logic                         pop;
	q_status_t                    q_status;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// register writes; segment multiples are formed from the write data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_count_q   <= LANE_W'(1);
			lanes_eff_q    <= LANE_W'(1);
			column_count_q <= QCNT_W'(8);
			for (int k = 0; k < MULT_N; k++) begin
				segm_q[k] <= POS_W'(k * 2);
			end
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_LANE_COUNT: begin
					lane_count_q <= pwdata[LANE_W-1:0];
					lanes_eff_q  <= (pwdata[LANE_W-1:0] == '0) ? LANE_W'(1)
						: pwdata[LANE_W-1:0];
				end
				REG_COLUMN_COUNT: begin
					column_count_q <= pwdata[QCNT_W-1:0];
					for (int k = 0; k < MULT_N; k++) begin
						segm_q[k] <= POS_W'(k) * POS_W'(pwdata[QCNT_W-1:2]);
					end
				end
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			REG_LANE_COUNT:   prdata = APB_DATA_W'(lane_count_q);
			REG_COLUMN_COUNT: prdata = APB_DATA_W'(column_count_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.lanes = lanes_eff_q;
	assign cfg.q     = column_count_q;
	assign cfg.segm  = segm_q;

	assign busy   = q_status.full;
	assign accept = start && !busy;

	rbim_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.accept       (accept),
		.lane_index   (lane_index),
		.column_index (column_index),
		.first_pass   (first_pass),
		.rand_low     (rand_low),
		.rand_high    (rand_high),
		.push         (push),
		.push_job     (push_job)
	);

	rbim_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.status   (q_status)
	);

	rbim_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.status     (q_status),
		.head_job   (head_job),
		.pop        (pop),
		.done       (done),
		.ref_lane   (ref_lane),
		.ref_column (ref_column),
		.empty_set  (empty_set)
	);

endmodule

>>> rtl/rbim_checker.sv
// Port-level assertions for the reference block index map, bound to its top.
// Depends on rbim_pkg for port widths.
module rbim_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [rbim_pkg::APB_ADDR_W-1:0] paddr,
	input logic [rbim_pkg::APB_DATA_W-1:0] pwdata,
	input logic [rbim_pkg::APB_DATA_W-1:0] prdata,
	input logic                            pready,
	input logic                            start,
	input logic                            busy,
	input logic [rbim_pkg::LANE_W-1:0]     lane_index,
	input logic [rbim_pkg::COL_W-1:0]      column_index,
	input logic                            first_pass,
	input logic [rbim_pkg::RAND_W-1:0]     rand_low,
	input logic [rbim_pkg::RAND_W-1:0]     rand_high,
	input logic                            done,
	input logic [rbim_pkg::LANE_W-1:0]     ref_lane,
	input logic [rbim_pkg::COL_W-1:0]      ref_column,
	input logic                            empty_set
);
	import rbim_pkg::*;

	localparam int LATENCY = 12;

	// an empty candidate set reports lane and column zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && empty_set |-> ref_lane == '0 && ref_column == '0)
		else $error("empty result with nonzero lane or column");

	// every accepted item returns after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result missing after accepted item");

	// no result without an item accepted the matching number of cycles before
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching accepted item");

	// register port never inserts wait states
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("pready low during a transfer");

endmodule

bind reference_block_index_map rbim_checker u_rbim_checker (.*);

>>> verif/reference_block_index_map_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for reference_block_index_map: directed table, then random phases.
// Depends on rbim_pkg and the block's RTL; predicts each untyped reference from its own copy of
// the lane and column counts, and reads back each register it writes over APB.
module reference_block_index_map_tb;
	import rbim_pkg::*;

	// one item offered to the block
	typedef struct packed {
		logic [LANE_W-1:0] lane_index;
		logic [COL_W-1:0]  column_index;
		logic              first_pass;
		logic [RAND_W-1:0] rand_low;
		logic [RAND_W-1:0] rand_high;
	} block_item_t;

	// referenced block as reported by the block
	typedef struct packed {
		logic [LANE_W-1:0] ref_lane;
		logic [COL_W-1:0]  ref_column;
		logic              empty_set;
	} block_ref_t;

	// directed row: counts to run under, the item, and a typed answer where obvious
	typedef struct packed {
		logic [LANE_W-1:0] lanes;
		logic [QCNT_W-1:0] cols;
		block_item_t       item;
		logic              typed;
		block_ref_t        answer;
	} dir_row_t;

	localparam int NUM_DIRECTED   = 23;
	localparam int NUM_PHASES     = 10;
	localparam int ITEMS_PER_PHASE = 55;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [LANE_W-1:0] lane_index = '0;
	logic [COL_W-1:0] column_index = '0;
	logic first_pass = 1'b0;
	logic [RAND_W-1:0] rand_low = '0;
	logic [RAND_W-1:0] rand_high = '0;
	logic done;
	logic [LANE_W-1:0] ref_lane;
	logic [COL_W-1:0] ref_column;
	logic empty_set;

	// shadow of the register file, as the block should hold it
	logic [LANE_W-1:0] cfg_lanes = 8'd1;
	logic [QCNT_W-1:0] cfg_cols = 25'd8;

	block_ref_t expected_refs[$];
	int mismatch_count = 0;

	reference_block_index_map dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.lane_index   (lane_index),
		.column_index (column_index),
		.first_pass   (first_pass),
		.rand_low     (rand_low),
		.rand_high    (rand_high),
		.done         (done),
		.ref_lane     (ref_lane),
		.ref_column   (ref_column),
		.empty_set    (empty_set)
	);

	always #4 clk = ~clk;

	// directed rows; typed answers only where they follow at a glance
	dir_row_t directed_rows [NUM_DIRECTED] = '{
		// reset counts: column zero means the last column, first pass, J1 zero
		'{8'd1, 25'd8, '{8'd0, 24'd0, 1'b1, 32'h0, 32'h0}, 1'b1, '{8'd0, 24'd5, 1'b0}},
		// J1 at its maximum picks the oldest candidate
		'{8'd1, 25'd8, '{8'd0, 24'd2, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1,
			'{8'd0, 24'd0, 1'b0}},
		// first slice of the first pass with nothing before it
		'{8'd1, 25'd8, '{8'd0, 24'd1, 1'b1, 32'h12345678, 32'h0}, 1'b1, '{8'd0, 24'd0, 1'b1}},
		// column equal to the column count
		'{8'd1, 25'd8, '{8'd255, 24'd8, 1'b0, 32'hDEADBEEF, 32'h1}, 1'b1,
			'{8'd0, 24'd0, 1'b1}},
		// column far out of range
		'{8'd1, 25'd8, '{8'd0, 24'hFFFFFF, 1'b0, 32'hFFFFFFFF, 32'h0}, 1'b1,
			'{8'd0, 24'd0, 1'b1}},
		// later pass, own lane
		'{8'd1, 25'd8, '{8'd0, 24'd5, 1'b0, 32'h9E3779B9, 32'h0}, 1'b0, '0},
		// later pass, other lane, column on a segment boundary
		'{8'd1, 25'd8, '{8'd7, 24'd4, 1'b0, 32'h7F4A7C15, 32'h0}, 1'b0, '0},
		// lane index out of range, forced lane in the first slice
		'{8'd4, 25'd64, '{8'd255, 24'd10, 1'b1, 32'hC2B2AE35, 32'h5}, 1'b0, '0},
		'{8'd4, 25'd64, '{8'd255, 24'd16, 1'b0, 32'h85EBCA6B, 32'hFFFFFFFF}, 1'b0, '0},
		'{8'd4, 25'd64, '{8'd3, 24'd17, 1'b0, 32'h27D4EB2F, 32'h3}, 1'b0, '0},
		'{8'd4, 25'd64, '{8'd1, 24'd32, 1'b1, 32'h165667B1, 32'h0}, 1'b0, '0},
		// zero lane count acts as one lane
		'{8'd0, 25'd64, '{8'd0, 24'd63, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0},
		// short matrix: every item empty
		'{8'd0, 25'd3, '{8'd0, 24'd1, 1'b0, 32'h55555555, 32'hAAAAAAAA}, 1'b1,
			'{8'd0, 24'd0, 1'b1}},
		'{8'd255, 25'd0, '{8'd0, 24'd0, 1'b1, 32'h0, 32'h0}, 1'b1, '{8'd0, 24'd0, 1'b1}},
		// segment of one column, deepest slice
		'{8'd255, 25'd7, '{8'd2, 24'd6, 1'b0, 32'hA5A5A5A5, 32'h9}, 1'b0, '0},
		'{8'd255, 25'd7, '{8'd0, 24'd0, 1'b1, 32'hFFFFFFFF, 32'h0}, 1'b0, '0},
		'{8'd255, 25'd5, '{8'd254, 24'd4, 1'b0, 32'h3C6EF372, 32'd254}, 1'b0, '0},
		// widest column count: last column does not fit the column field
		'{8'd255, 25'h1FFFFFF, '{8'd0, 24'd0, 1'b0, 32'hBB67AE85, 32'hFFFFFFFF}, 1'b0, '0},
		'{8'd255, 25'h1FFFFFF, '{8'd128, 24'hFFFFFF, 1'b1, 32'h0, 32'h80000000}, 1'b0, '0},
		// largest legal matrix
		'{8'd200, 25'd16777216, '{8'd0, 24'd0, 1'b0, 32'h0, 32'h0}, 1'b0, '0},
		'{8'd200, 25'd16777216, '{8'd17, 24'hFFFFFF, 1'b1, 32'hFFFFFFFF, 32'd17}, 1'b0, '0},
		'{8'd200, 25'd16777216, '{8'd199, 24'd4194304, 1'b0, 32'h510E527F, 32'd12345},
			1'b0, '0},
		// back to the reset counts
		'{8'd1, 25'd8, '{8'd0, 24'd3, 1'b0, 32'h9B05688C, 32'h0}, 1'b0, '0}
	};

	// predicted reference block for one item under the shadow counts
	function automatic block_ref_t map_reference(input block_item_t it);
		logic [63:0] j, q, seg, lanes, lane, slice, range_base, span_a, card, x, y, z, col;
		block_ref_t r;
		r = '0;
		r.empty_set = 1'b1;
		q = 64'(cfg_cols);
		seg = q >> 2;
		lanes = (cfg_lanes == 0) ? 64'd1 : 64'(cfg_lanes);
		lane = 64'(it.rand_high) % lanes;
		j = 64'(it.column_index);
		if (j == 0 && q > 0) begin
			j = q - 1;
		end
		if (seg == 0 || j >= q) begin
			return r;
		end
		slice = j / seg;
		if (it.first_pass) begin
			range_base = 0;
			span_a = 0;
			if (slice == 0) begin
				lane = 64'(it.lane_index);
				card = (j > 0) ? j - 1 : 0;
			end else begin
				card = slice * seg;
			end
		end else begin
			range_base = (slice + 1) * seg;
			span_a = (q > range_base) ? q - range_base : 0;
			if (lane == 64'(it.lane_index)) begin
				card = span_a + ((j > 0) ? j - 1 : 0);
			end else begin
				card = span_a + slice * seg;
				// a boundary column may not reference the block just before it
				if (j % seg == 0 && card > 0) begin
					card = card - 1;
				end
			end
		end
		if (card == 0) begin
			return r;
		end
		x = (64'(it.rand_low) * 64'(it.rand_low)) >> 32;
		y = (card * x) >> 32;
		z = card - 1 - y;
		col = (z < span_a) ? range_base + z : z - span_a;
		r.ref_lane = lane[LANE_W-1:0];
		r.ref_column = col[COL_W-1:0];
		r.empty_set = 1'b0;
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		case ($urandom_range(0, 9))
			6, 7, 8: return $urandom_range(1, 3);
			9: return $urandom_range(5, 30);
			default: return 0;
		endcase
	endfunction

	// columns in range, near segment boundaries, or anywhere in the field
	function automatic logic [COL_W-1:0] pick_column();
		logic [63:0] q, seg, lim, c;
		q = 64'(cfg_cols);
		seg = q >> 2;
		case ($urandom_range(0, 9))
			0: c = 64'($urandom());
			1: c = 0;
			2, 3: c = seg * $urandom_range(0, 4) + $urandom_range(0, 2) - 1;
			default: begin
				lim = (q > 64'h1000000) ? 64'hFFFFFF : q - 1;
				c = (q == 0) ? 0 : 64'($urandom_range(0, 32'(lim)));
			end
		endcase
		return c[COL_W-1:0];
	endfunction

	// random item; the own lane is chosen often so later passes hit it
	function automatic block_item_t make_item();
		block_item_t it;
		int lanes_eff;
		lanes_eff = (cfg_lanes == 0) ? 1 : int'(cfg_lanes);
		it.rand_high = $urandom();
		case ($urandom_range(0, 9))
			0: it.rand_low = '0;
			1: it.rand_low = '1;
			default: it.rand_low = $urandom();
		endcase
		case ($urandom_range(0, 3))
			0: it.lane_index = LANE_W'($urandom_range(0, 255));
			3: it.lane_index = LANE_W'($urandom_range(0, lanes_eff - 1));
			default: it.lane_index = LANE_W'(it.rand_high % lanes_eff);
		endcase
		it.first_pass = 1'($urandom_range(0, 1));
		it.column_index = pick_column();
		return it;
	endfunction

	// APB write, shadow update, then read back
	task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
		logic [APB_DATA_W-1:0] readback;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_LANE_COUNT) begin
			cfg_lanes = value[LANE_W-1:0];
		end else begin
			cfg_cols = value[QCNT_W-1:0];
		end
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (readback != value) begin
			$error("prdata at %s: expected 0x%0h, got 0x%0h", idx.name(), value, readback);
			mismatch_count++;
		end
	endtask

	// offer one item and queue its expected reference once taken
	task automatic send_item(input block_item_t it, input logic typed, input block_ref_t answer);
		@(negedge clk);
		start = 1'b1;
		lane_index = it.lane_index;
		column_index = it.column_index;
		first_pass = it.first_pass;
		rand_low = it.rand_low;
		rand_high = it.rand_high;
		do @(posedge clk); while (busy);
		expected_refs.push_back(typed ? answer : map_reference(it));
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// stop offering and wait for every pending reference
	task automatic wait_results_drained();
		@(negedge clk);
		start = 1'b0;
		while (expected_refs.size() != 0) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		block_ref_t want;
		if (arst_n && done) begin
			if (expected_refs.size() == 0) begin
				$error("unexpected item: ref_lane %0d ref_column %0d empty_set %0b",
					ref_lane, ref_column, empty_set);
				mismatch_count++;
			end else begin
				want = expected_refs.pop_front();
				if (ref_lane !== want.ref_lane) begin
					$error("ref_lane: expected %0d, got %0d", want.ref_lane, ref_lane);
					mismatch_count++;
				end
				if (ref_column !== want.ref_column) begin
					$error("ref_column: expected %0d, got %0d", want.ref_column, ref_column);
					mismatch_count++;
				end
				if (empty_set !== want.empty_set) begin
					$error("empty_set: expected %0b, got %0b", want.empty_set, empty_set);
					mismatch_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [LANE_W-1:0] new_lanes;
		logic [QCNT_W-1:0] new_cols;
		bit burst;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table, counts changed only with nothing in flight
		foreach (directed_rows[r]) begin
			if (directed_rows[r].lanes != cfg_lanes || directed_rows[r].cols != cfg_cols) begin
				wait_results_drained();
				write_reg(REG_LANE_COUNT, APB_DATA_W'(directed_rows[r].lanes));
				write_reg(REG_COLUMN_COUNT, APB_DATA_W'(directed_rows[r].cols));
			end
			send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].answer);
			idle_cycles(pick_gap());
		end

		// random phases over several matrix shapes
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p % 5)
				0: new_lanes = 8'd1;
				1: new_lanes = 8'd255;
				2: new_lanes = 8'd0;
				3: new_lanes = LANE_W'($urandom_range(2, 8));
				default: new_lanes = LANE_W'($urandom_range(1, 255));
			endcase
			case (p)
				0: new_cols = 25'd8;
				1: new_cols = QCNT_W'($urandom_range(8, 64));
				2: new_cols = 25'd16777216;
				3: new_cols = QCNT_W'($urandom_range(0, 7));
				4: new_cols = QCNT_W'($urandom_range(16, 1024) * 4);
				5: new_cols = 25'h1FFFFFF;
				6: new_cols = QCNT_W'($urandom_range(8, 200));
				7: new_cols = QCNT_W'($urandom());
				8: new_cols = QCNT_W'($urandom_range(1, 64) * 4);
				default: new_cols = QCNT_W'($urandom_range(8, 40));
			endcase
			wait_results_drained();
			write_reg(REG_LANE_COUNT, APB_DATA_W'(new_lanes));
			write_reg(REG_COLUMN_COUNT, APB_DATA_W'(new_cols));
			burst = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// one pause mid-phase until the pipeline is empty
				if (p == 4 && n == 20) begin
					wait_results_drained();
				end
				send_item(make_item(), 1'b0, '0);
				if (!burst) begin
					idle_cycles(pick_gap());
				end
			end
		end

		wait_results_drained();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// run limit
	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
